/* hw/rtl/hbp_pkg.sv */
// shared types, constants and helper functions for the hybrid branch predictor
// no dependencies; imported by the channel interfaces and hybrid_branch_predictor
package hbp_pkg;

  localparam int ADDR_W     = 32;
  localparam int COUNT_W    = 32;
  localparam int CFG_DATA_W = 4;
  localparam int CFG_IDX_W  = 8;
  // holds a clamped index width, up to the largest table size allowed
  localparam int WIDTH_W    = 5;
  localparam int OBUF_DEPTH = 4;
  localparam int OBUF_PTR_W = 2;
  localparam int OBUF_CNT_W = 3;

  typedef logic [1:0] ctr_t;

  localparam ctr_t CTR_WEAK_TAKEN = 2'd2;
  localparam ctr_t CTR_WEAK_BIMOD = 2'd1;
  localparam ctr_t CTR_MAX        = 2'd3;
  localparam ctr_t CTR_MIN        = 2'd0;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GSHARE_BITS  = 8'd0,
    CFG_HISTORY_BITS = 8'd1,
    CFG_BIMODAL_BITS = 8'd2,
    CFG_CHOOSER_BITS = 8'd3
  } cfg_reg_e;

  typedef struct packed {
    logic [ADDR_W-1:0] branch_address;
    logic              taken;
  } branch_t;

  typedef struct packed {
    logic               predicted_taken;
    logic               used_gshare;
    logic               mispredicted;
    logic [COUNT_W-1:0] prediction_count;
    logic [COUNT_W-1:0] misprediction_count;
  } result_t;

  // two-bit saturating counter step
  function automatic ctr_t train(ctr_t c, logic up);
    ctr_t r;
    if (up) begin
      r = (c == CTR_MAX) ? CTR_MAX : c + 2'd1;
    end else begin
      r = (c == CTR_MIN) ? CTR_MIN : c - 2'd1;
    end
    return r;
  endfunction

  // zero reads as one, anything above the table size reads as the table size
  function automatic logic [WIDTH_W-1:0] clamp_bits(logic [CFG_DATA_W-1:0] w,
                                                    logic [WIDTH_W-1:0] max_bits);
    logic [WIDTH_W-1:0] wx;
    wx = WIDTH_W'(w);
    if (wx == '0) begin
      return WIDTH_W'(1);
    end
    if (wx > max_bits) begin
      return max_bits;
    end
    return wx;
  endfunction

endpackage

/* hw/rtl/hbp_branch_if.sv */
// branch input channel: valid/ready handshake with address and outcome
// depends on hbp_pkg
interface hbp_branch_if import hbp_pkg::*; ();
  logic    valid;
  logic    ready;
  branch_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* hw/rtl/hbp_result_if.sv */
// result output channel: valid/ready handshake with prediction and counts
// depends on hbp_pkg
interface hbp_result_if import hbp_pkg::*; ();
  logic    valid;
  logic    ready;
  result_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* hw/rtl/hbp_cfg_if.sv */
// configuration write channel: register index and write data
// depends on hbp_pkg
interface hbp_cfg_if import hbp_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

/* hw/rtl/hbp_ram.sv */
// generic simple dual-port ram: one write port, one read port, registered read
// no dependencies
module hbp_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* hw/rtl/hybrid_branch_predictor.sv */
// tournament branch predictor: gshare and bimodal tables with a chooser table
// depends on hbp_pkg, hbp_branch_if, hbp_result_if, hbp_cfg_if and hbp_ram
//
//   port    dir  contents
//   branch  in   branch_address, taken
//   result  out  predicted_taken, used_gshare, mispredicted, both counts
//   cfg     in   index 0..3 (gshare, history, bimodal, chooser bits), 4-bit data
//
// one branch per cycle while branch.ready is high; a result passes through the table read,
// then update and write-back into a 4-entry output buffer
// after reset the tables are swept over 2^max(index maxima) entries, 4096 at the
// default sizes; branch.ready stays low meanwhile, cfg writes are taken always
// a stalled result side fills the buffer, then branch.ready drops
module hybrid_branch_predictor import hbp_pkg::*; #(
  parameter int GSHARE_INDEX_MAX  = 12,
  parameter int BIMODAL_INDEX_MAX = 12,
  parameter int CHOOSER_INDEX_MAX = 12
) (
  input  logic clk,
  input  logic rst,
  hbp_cfg_if.sink      cfg,
  hbp_branch_if.sink   branch,
  hbp_result_if.source result
);

  localparam int GW = GSHARE_INDEX_MAX;
  localparam int BW = BIMODAL_INDEX_MAX;
  localparam int CW = CHOOSER_INDEX_MAX;
  localparam int SW = (GW > BW) ? ((GW > CW) ? GW : CW) : ((BW > CW) ? BW : CW);

  // configuration
  logic [CFG_DATA_W-1:0] gshare_bits, history_bits, bimodal_bits, chooser_bits;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      gshare_bits  <= CFG_DATA_W'(12);
      history_bits <= CFG_DATA_W'(8);
      bimodal_bits <= CFG_DATA_W'(12);
      chooser_bits <= CFG_DATA_W'(12);
    end else if (cfg.valid) begin
      unique case (cfg.index)
        CFG_GSHARE_BITS:  gshare_bits  <= cfg.data;
        CFG_HISTORY_BITS: history_bits <= cfg.data;
        CFG_BIMODAL_BITS: bimodal_bits <= cfg.data;
        CFG_CHOOSER_BITS: chooser_bits <= cfg.data;
        default: ;
      endcase
    end
  end

  // table sweep after reset
  logic          sweeping;
  logic [SW-1:0] sweep_idx;

  always_ff @(posedge clk) begin
    if (rst) begin
      sweeping  <= 1'b1;
      sweep_idx <= '0;
    end else if (sweeping) begin
      sweep_idx <= sweep_idx + 1'b1;
      if (&sweep_idx) begin
        sweeping <= 1'b0;
      end
    end
  end

  // index computation at transfer
  logic [WIDTH_W-1:0] m1, m2, kc, n_eff, hist_shift;
  logic [GW-1:0]      gmask, hist, hist_next, gi;
  logic [BW-1:0]      bmask, bi;
  logic [CW-1:0]      cmask, ci;
  logic               accept;

  assign accept = branch.valid && branch.ready;

  always_comb begin
    m1 = clamp_bits(gshare_bits, WIDTH_W'(GSHARE_INDEX_MAX));
    m2 = clamp_bits(bimodal_bits, WIDTH_W'(BIMODAL_INDEX_MAX));
    kc = clamp_bits(chooser_bits, WIDTH_W'(CHOOSER_INDEX_MAX));
    n_eff = (WIDTH_W'(history_bits) > m1) ? m1 : WIDTH_W'(history_bits);
    hist_shift = m1 - n_eff;
    for (int i = 0; i < GW; i++) gmask[i] = (m1 > WIDTH_W'(i));
    for (int i = 0; i < BW; i++) bmask[i] = (m2 > WIDTH_W'(i));
    for (int i = 0; i < CW; i++) cmask[i] = (kc > WIDTH_W'(i));
    gi = branch.data.branch_address[GW+1:2];
    if (n_eff != '0) begin
      gi = gi ^ (hist << hist_shift);
    end
    gi = gi & gmask;
    bi = branch.data.branch_address[BW+1:2] & bmask;
    ci = branch.data.branch_address[CW+1:2] & cmask;
  end

  // the outcome is known at transfer, so history moves on right away
  always_comb begin
    hist_next = hist;
    if (n_eff != '0) begin
      hist_next = hist >> 1;
      if (branch.data.taken) begin
        hist_next = hist_next | (GW'(1) << (n_eff - WIDTH_W'(1)));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hist <= '0;
    end else if (accept) begin
      hist <= hist_next;
    end
  end

  // update stage
  logic          s1_vld, s1_taken;
  logic [GW-1:0] s1_gi;
  logic [BW-1:0] s1_bi;
  logic [CW-1:0] s1_ci;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld <= 1'b0;
    end else begin
      s1_vld <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_taken <= branch.data.taken;
      s1_gi    <= gi;
      s1_bi    <= bi;
      s1_ci    <= ci;
    end
  end

  ctr_t g_rd, b_rd, c_rd, g_cur, b_cur, c_cur;
  ctr_t g_wdata, b_wdata, c_wdata;
  logic g_upd, b_upd, c_upd;
  logic g_we, b_we, c_we;
  logic [GW-1:0] g_waddr;
  logic [BW-1:0] b_waddr;
  logic [CW-1:0] c_waddr;

  // last write per table, covers a read issued on the cycle of that write
  logic          g_fw_vld, b_fw_vld, c_fw_vld;
  logic [GW-1:0] g_fw_addr;
  logic [BW-1:0] b_fw_addr;
  logic [CW-1:0] c_fw_addr;
  ctr_t          g_fw_data, b_fw_data, c_fw_data;

  logic pg, pb, use_g, pred, miss;
  ctr_t g_new, b_new, c_new;

  always_comb begin
    g_cur = (g_fw_vld && g_fw_addr == s1_gi) ? g_fw_data : g_rd;
    b_cur = (b_fw_vld && b_fw_addr == s1_bi) ? b_fw_data : b_rd;
    c_cur = (c_fw_vld && c_fw_addr == s1_ci) ? c_fw_data : c_rd;
    pg    = g_cur[1];
    pb    = b_cur[1];
    use_g = c_cur[1];
    pred  = use_g ? pg : pb;
    miss  = pred != s1_taken;
    g_upd = s1_vld && use_g;
    b_upd = s1_vld && !use_g;
    // chooser moves only when exactly one side was right
    c_upd = s1_vld && (pg != pb);
    g_new = train(g_cur, s1_taken);
    b_new = train(b_cur, s1_taken);
    c_new = train(c_cur, pg == s1_taken);
  end

  always_comb begin
    if (sweeping) begin
      g_we    = 1'b1;
      b_we    = 1'b1;
      c_we    = 1'b1;
      g_waddr = sweep_idx[GW-1:0];
      b_waddr = sweep_idx[BW-1:0];
      c_waddr = sweep_idx[CW-1:0];
      g_wdata = CTR_WEAK_TAKEN;
      b_wdata = CTR_WEAK_TAKEN;
      c_wdata = CTR_WEAK_BIMOD;
    end else begin
      g_we    = g_upd;
      b_we    = b_upd;
      c_we    = c_upd;
      g_waddr = s1_gi;
      b_waddr = s1_bi;
      c_waddr = s1_ci;
      g_wdata = g_new;
      b_wdata = b_new;
      c_wdata = c_new;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      g_fw_vld <= 1'b0;
      b_fw_vld <= 1'b0;
      c_fw_vld <= 1'b0;
    end else begin
      if (g_upd) g_fw_vld <= 1'b1;
      if (b_upd) b_fw_vld <= 1'b1;
      if (c_upd) c_fw_vld <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (g_upd) begin
      g_fw_addr <= s1_gi;
      g_fw_data <= g_new;
    end
    if (b_upd) begin
      b_fw_addr <= s1_bi;
      b_fw_data <= b_new;
    end
    if (c_upd) begin
      c_fw_addr <= s1_ci;
      c_fw_data <= c_new;
    end
  end

  hbp_ram #(.WIDTH(2), .DEPTH(2 ** GW)) u_gshare_ram (
    .clk   (clk),
    .we    (g_we),
    .waddr (g_waddr),
    .wdata (g_wdata),
    .raddr (gi),
    .rdata (g_rd)
  );

  hbp_ram #(.WIDTH(2), .DEPTH(2 ** BW)) u_bimodal_ram (
    .clk   (clk),
    .we    (b_we),
    .waddr (b_waddr),
    .wdata (b_wdata),
    .raddr (bi),
    .rdata (b_rd)
  );

  hbp_ram #(.WIDTH(2), .DEPTH(2 ** CW)) u_chooser_ram (
    .clk   (clk),
    .we    (c_we),
    .waddr (c_waddr),
    .wdata (c_wdata),
    .raddr (ci),
    .rdata (c_rd)
  );

  // running counts, saturating
  logic [COUNT_W-1:0] pred_count, miss_count, pred_count_next, miss_count_next;

  always_comb begin
    pred_count_next = (&pred_count) ? pred_count : pred_count + 1'b1;
    miss_count_next = (miss && !(&miss_count)) ? miss_count + 1'b1 : miss_count;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pred_count <= '0;
      miss_count <= '0;
    end else if (s1_vld) begin
      pred_count <= pred_count_next;
      miss_count <= miss_count_next;
    end
  end

  // output buffer
  result_t                obuf [OBUF_DEPTH];
  logic [OBUF_PTR_W-1:0]  wr_ptr, rd_ptr;
  logic [OBUF_CNT_W-1:0]  obuf_cnt, obuf_cnt_next;
  logic                   pop;

  assign pop = result.valid && result.ready;
  assign result.valid = obuf_cnt != '0;
  assign result.data  = obuf[rd_ptr];
  // room for the item in the update stage plus one more
  assign branch.ready = !sweeping &&
                        ((obuf_cnt + OBUF_CNT_W'(s1_vld)) < OBUF_CNT_W'(OBUF_DEPTH));

  always_comb begin
    obuf_cnt_next = obuf_cnt + OBUF_CNT_W'(s1_vld) - OBUF_CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr   <= '0;
      rd_ptr   <= '0;
      obuf_cnt <= '0;
    end else begin
      obuf_cnt <= obuf_cnt_next;
      if (s1_vld) wr_ptr <= wr_ptr + 1'b1;
      if (pop)    rd_ptr <= rd_ptr + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_vld) begin
      obuf[wr_ptr] <= '{
        predicted_taken:     pred,
        used_gshare:         use_g,
        mispredicted:        miss,
        prediction_count:    pred_count_next,
        misprediction_count: miss_count_next
      };
    end
  end

endmodule

/* tb/tb.sv */
// self-checking testbench for hybrid_branch_predictor: predicts every branch transfer
// and compares each result field by field; depends on hbp_pkg and the three channel interfaces
module tb;
  import hbp_pkg::*;

  localparam int TABLE_MAX   = 12;
  localparam int TABLE_DEPTH = 1 << TABLE_MAX;
  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_CYCLES = 300;
  localparam int SETTLE      = 4;
  // an index past the last register, the block must ignore it
  localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED = 8'd200;

  typedef struct {
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] value;
  } reg_write_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  hbp_cfg_if    cfg_ch ();
  hbp_branch_if br_ch ();
  hbp_result_if res_ch ();

  hybrid_branch_predictor uut (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg_ch),
    .branch (br_ch),
    .result (res_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  branch_t    branch_backlog[$];
  reg_write_t reg_writes[$];
  result_t    pending_outcomes[$];

  int sender_idle   = 0;
  int receiver_idle = 0;
  int hold_epoch    = 0;
  int seen_epoch    = 0;
  int hold_left     = 0;
  int errors        = 0;
  int cycles        = 0;

  // predictor state
  ctr_t                  gshare_tbl  [TABLE_DEPTH];
  ctr_t                  bimodal_tbl [TABLE_DEPTH];
  ctr_t                  chooser_tbl [TABLE_DEPTH];
  logic [31:0]           ghist;
  logic [COUNT_W-1:0]    pred_total;
  logic [COUNT_W-1:0]    miss_total;
  logic [CFG_DATA_W-1:0] cfg_gshare, cfg_history, cfg_bimodal, cfg_chooser;

  function automatic void clear_predictor();
    foreach (gshare_tbl[i]) gshare_tbl[i] = CTR_WEAK_TAKEN;
    foreach (bimodal_tbl[i]) bimodal_tbl[i] = CTR_WEAK_TAKEN;
    foreach (chooser_tbl[i]) chooser_tbl[i] = CTR_WEAK_BIMOD;
    ghist       = '0;
    pred_total  = '0;
    miss_total  = '0;
    cfg_gshare  = 4'd12;
    cfg_history = 4'd8;
    cfg_bimodal = 4'd12;
    cfg_chooser = 4'd12;
  endfunction

  // zero width acts as one, anything past the table size acts as the table size
  function automatic int eff_width(logic [CFG_DATA_W-1:0] w);
    int v;
    v = int'(w);
    if (v == 0) return 1;
    if (v > TABLE_MAX) return TABLE_MAX;
    return v;
  endfunction

  function automatic logic [31:0] low_bits(int w);
    return (32'd1 << w) - 32'd1;
  endfunction

  function automatic ctr_t step_ctr(ctr_t c, logic up);
    if (up) return (c == CTR_MAX) ? CTR_MAX : ctr_t'(c + 2'd1);
    return (c == CTR_MIN) ? CTR_MIN : ctr_t'(c - 2'd1);
  endfunction

  function automatic result_t predict_branch(branch_t b);
    int          m1, m2, k, n;
    logic [31:0] pc, gi, bi, ci;
    logic        pg, pb, pick_g, guess;
    result_t     r;
    m1 = eff_width(cfg_gshare);
    m2 = eff_width(cfg_bimodal);
    k  = eff_width(cfg_chooser);
    n  = int'(cfg_history);
    if (n > m1) n = m1;
    pc = b.branch_address >> 2;
    gi = pc & low_bits(m1);
    if (n > 0) gi = gi ^ (ghist << (m1 - n));
    gi = gi & low_bits(m1);
    bi = pc & low_bits(m2);
    ci = pc & low_bits(k);

    pg     = gshare_tbl[gi] >= CTR_WEAK_TAKEN;
    pb     = bimodal_tbl[bi] >= CTR_WEAK_TAKEN;
    pick_g = chooser_tbl[ci] >= CTR_WEAK_TAKEN;
    guess  = pick_g ? pg : pb;

    if (pick_g) gshare_tbl[gi] = step_ctr(gshare_tbl[gi], b.taken);
    else bimodal_tbl[bi] = step_ctr(bimodal_tbl[bi], b.taken);

    // outcome enters at the top of the active history
    if (n > 0) begin
      ghist = ghist >> 1;
      if (b.taken) ghist = ghist | (32'd1 << (n - 1));
      ghist = ghist & 32'h000F_FFFF;
    end

    if (pg == b.taken && pb != b.taken) chooser_tbl[ci] = step_ctr(chooser_tbl[ci], 1'b1);
    else if (pg != b.taken && pb == b.taken) chooser_tbl[ci] = step_ctr(chooser_tbl[ci], 1'b0);

    if (pred_total != '1) pred_total = pred_total + 1'b1;
    if (guess != b.taken && miss_total != '1) miss_total = miss_total + 1'b1;

    r.predicted_taken     = guess;
    r.used_gshare         = pick_g;
    r.mispredicted        = guess != b.taken;
    r.prediction_count    = pred_total;
    r.misprediction_count = miss_total;
    return r;
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      errors++;
    end
  endfunction

  // branch driver, also feeds the predictor on every transfer
  always @(posedge clk) begin
    if (rst) begin
      br_ch.valid <= 1'b0;
    end else begin
      if (br_ch.valid && br_ch.ready) pending_outcomes.push_back(predict_branch(br_ch.data));
      if (!br_ch.valid || br_ch.ready) begin
        if (branch_backlog.size() > 0 && $urandom_range(99) >= sender_idle) begin
          br_ch.valid <= 1'b1;
          br_ch.data  <= branch_backlog.pop_front();
        end else begin
          br_ch.valid <= 1'b0;
        end
      end
    end
  end

  // register write driver
  always @(posedge clk) begin
    if (rst) begin
      cfg_ch.valid <= 1'b0;
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_ch.index)
          CFG_GSHARE_BITS:  cfg_gshare  = cfg_ch.data;
          CFG_HISTORY_BITS: cfg_history = cfg_ch.data;
          CFG_BIMODAL_BITS: cfg_bimodal = cfg_ch.data;
          CFG_CHOOSER_BITS: cfg_chooser = cfg_ch.data;
          default: ;
        endcase
      end
      if (!cfg_ch.valid || cfg_ch.ready) begin
        if (reg_writes.size() > 0) begin
          reg_write_t w;
          w = reg_writes.pop_front();
          cfg_ch.valid <= 1'b1;
          cfg_ch.index <= w.index;
          cfg_ch.data  <= w.value;
        end else begin
          cfg_ch.valid <= 1'b0;
        end
      end
    end
  end

  // result side ready, with a long hold-off whenever hold_epoch moves
  always @(posedge clk) begin
    if (rst) begin
      res_ch.ready <= 1'b0;
    end else if (hold_epoch != seen_epoch) begin
      seen_epoch   <= hold_epoch;
      hold_left    <= HOLD_CYCLES;
      res_ch.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left    <= hold_left - 1;
      res_ch.ready <= 1'b0;
    end else begin
      res_ch.ready <= $urandom_range(99) >= receiver_idle;
    end
  end

  // result checker and run limit
  always @(posedge clk) begin
    result_t want;
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
    if (!rst && res_ch.valid && res_ch.ready) begin
      if (pending_outcomes.size() == 0) begin
        $error("result transfer with no prediction outstanding");
        errors++;
      end else begin
        want = pending_outcomes.pop_front();
        check_field("predicted_taken", 32'(want.predicted_taken),
                    32'(res_ch.data.predicted_taken));
        check_field("used_gshare", 32'(want.used_gshare), 32'(res_ch.data.used_gshare));
        check_field("mispredicted", 32'(want.mispredicted), 32'(res_ch.data.mispredicted));
        check_field("prediction_count", want.prediction_count, res_ch.data.prediction_count);
        check_field("misprediction_count", want.misprediction_count,
                    res_ch.data.misprediction_count);
      end
    end
  end

  function automatic void add_branch(logic [31:0] addr, logic t);
    branch_t b;
    b.branch_address = addr;
    b.taken          = t;
    branch_backlog.push_back(b);
  endfunction

  function automatic void add_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] v);
    reg_write_t w;
    w.index = idx;
    w.value = v;
    reg_writes.push_back(w);
  endfunction

  // mostly loop branches and correlated pairs over a small address pool, some noise
  function automatic void add_traffic(int target);
    logic [31:0] pool[16];
    int          made, kind, trip, reps;
    logic [31:0] a, b;
    logic        t;
    foreach (pool[i]) pool[i] = $urandom;
    made = 0;
    while (made < target) begin
      kind = $urandom_range(9);
      if (kind < 5) begin
        a    = pool[$urandom_range(15)];
        trip = $urandom_range(2, 9);
        reps = $urandom_range(1, 3);
        repeat (reps) begin
          for (int j = 0; j < trip; j++) add_branch(a, j != trip - 1);
          made += trip;
        end
      end else if (kind < 8) begin
        a = pool[$urandom_range(15)];
        b = pool[$urandom_range(15)];
        t = 1'($urandom_range(1));
        add_branch(a, t);
        add_branch(b, t);
        made += 2;
      end else begin
        add_branch($urandom, 1'($urandom_range(1)));
        made++;
      end
    end
  endfunction

  task automatic wait_idle();
    while (branch_backlog.size() > 0 || br_ch.valid || pending_outcomes.size() > 0)
      @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic run_phase(int m1, int n, int m2, int k, int s_idle, int r_idle,
                           int count, bit squeeze);
    wait_idle();
    add_write(CFG_GSHARE_BITS, CFG_DATA_W'(m1));
    add_write(CFG_HISTORY_BITS, CFG_DATA_W'(n));
    add_write(CFG_BIMODAL_BITS, CFG_DATA_W'(m2));
    add_write(CFG_CHOOSER_BITS, CFG_DATA_W'(k));
    while (reg_writes.size() > 0 || cfg_ch.valid) @(negedge clk);
    @(negedge clk);
    sender_idle   = s_idle;
    receiver_idle = r_idle;
    if (squeeze) hold_epoch++;
    add_traffic(count);
  endtask

  initial begin
    br_ch.valid  = 1'b0;
    br_ch.data   = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = '0;
    cfg_ch.data  = '0;
    res_ch.ready = 1'b0;
    clear_predictor();
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: address extremes, then one branch trained up, down and back up
    sender_idle   = 24;
    receiver_idle = 72;
    add_branch(32'h0000_0000, 1'b1);
    add_branch(32'hFFFF_FFFF, 1'b0);
    add_branch(32'h0000_0003, 1'b1);
    add_branch(32'hFFFF_FFFC, 1'b1);
    add_branch(32'h8000_0000, 1'b0);
    add_branch(32'h7FFF_FFFF, 1'b1);
    add_branch(32'hAAAA_AAAA, 1'b0);
    add_branch(32'h5555_5555, 1'b1);
    repeat (4) add_branch(32'h0000_1000, 1'b1);
    repeat (6) add_branch(32'h0000_1000, 1'b0);
    repeat (4) add_branch(32'h0000_1000, 1'b1);

    run_phase(12, 12, 12, 12, 24, 72, 95, 1'b0);
    run_phase(1, 0, 1, 1, 24, 72, 95, 1'b0);
    // zero widths and history past the gshare width
    run_phase(0, 15, 0, 0, 24, 72, 95, 1'b0);
    run_phase(15, 15, 15, 15, 72, 24, 95, 1'b0);
    // history shrinks below what is held, small aliased tables
    run_phase(4, 6, 3, 2, 72, 24, 95, 1'b0);
    wait_idle();
    add_write(CFG_UNMAPPED, 4'hF);
    run_phase(8, 3, 10, 5, 0, 0, 95, 1'b1);
    run_phase(12, 8, 12, 12, 0, 0, 95, 1'b0);

    wait_idle();
    repeat (10) @(negedge clk);
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
